>>> rtl/fbik_pkg.sv
// Shared constants, item types and the arctangent table for the five-bar leg IK block.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package fbik_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 16;
	localparam int COORD_MAX_W      = 24;  // widest coordinate the block supports
	localparam int ATAN_LEN         = 24;
	localparam int NORM_STAGES      = 6;   // shifts of 32, 16, 8, 4, 2, 1
	localparam int NORM_W           = 41;  // larger operand normalised into [2^40, 2^41)
	localparam int ROT_W            = 45;
	localparam int ACC_W            = 26;
	localparam int LEN_W            = 15;
	localparam int ANGLE_W          = 15;

	localparam logic [13:0] ANG_90   = 14'd5760;
	localparam logic [13:0] ANG_180  = 14'd11520;
	localparam logic [14:0] BACK_MAX = 15'd23040;

	typedef enum logic {
		REG_UPPER = 1'b0,
		REG_LOWER = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]             tag;
		logic [COORD_MAX_W-1:0] ax;
		logic [COORD_MAX_W-1:0] az;
		logic                   x_zero;
		logic                   same_sign;
	} fbik_item_t;

	typedef struct packed {
		fbik_item_t item;
		logic       flag;
		logic       n_neg;
	} fbik_side_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [21:0] atan_entry(input int i);
		logic [21:0] v;
		case (i)
			0: v = 22'd2949120;
			1: v = 22'd1740967;
			2: v = 22'd919879;
			3: v = 22'd466945;
			4: v = 22'd234379;
			5: v = 22'd117304;
			6: v = 22'd58666;
			7: v = 22'd29335;
			8: v = 22'd14668;
			9: v = 22'd7334;
			10: v = 22'd3667;
			11: v = 22'd1833;
			12: v = 22'd917;
			13: v = 22'd458;
			14: v = 22'd229;
			15: v = 22'd115;
			16: v = 22'd57;
			17: v = 22'd29;
			18: v = 22'd14;
			19: v = 22'd7;
			20: v = 22'd4;
			21: v = 22'd2;
			22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/fbik_front.sv
// Front end: takes input items, forms absolute coordinates and quadrant class.
// Depends on fbik_pkg.
`default_nettype none

module fbik_front #(
	parameter int COORD_WIDTH = fbik_pkg::COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              leg_index,
	input  logic [COORD_WIDTH-1:0]  foot_x,
	input  logic [COORD_WIDTH-1:0]  foot_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output fbik_pkg::fbik_item_t    out_item
);
	import fbik_pkg::*;

	logic [COORD_WIDTH-1:0] ax_c, az_c;
	fbik_item_t             item_c, item_q;
	logic                   valid_q;

	assign ax_c = foot_x[COORD_WIDTH-1] ? COORD_WIDTH'(-foot_x) : foot_x;
	assign az_c = foot_z[COORD_WIDTH-1] ? COORD_WIDTH'(-foot_z) : foot_z;

	always_comb begin
		item_c.tag       = leg_index;
		item_c.ax        = COORD_MAX_W'(ax_c);
		item_c.az        = COORD_MAX_W'(az_c);
		item_c.x_zero    = (foot_x == '0);
		// -z/x negative: both nonzero with equal signs
		item_c.same_sign = (foot_x[COORD_WIDTH-1] == foot_z[COORD_WIDTH-1]) &&
			(foot_x != '0) && (foot_z != '0);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= item_c;
		end
	end

endmodule

`default_nettype wire

>>> rtl/fbik_queue.sv
// Short item queue between the front end and the arithmetic pipeline.
// Depends on fbik_pkg.
`default_nettype none

module fbik_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fbik_pkg::fbik_item_t in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fbik_pkg::fbik_item_t out_item
);
	import fbik_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	fbik_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push, pop;

	assign in_ready  = (count_q != (PTR_W+1)'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/fbik_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) for x, y >= 0, result in 1/64 degree.
// Normalising shifter, one stage per rotation, rounding stage. Depends on fbik_pkg.
`default_nettype none

module fbik_cordic #(
	parameter int CORDIC_STEPS = fbik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [fbik_pkg::NORM_W-1:0] x_in,
	input  logic [fbik_pkg::NORM_W-1:0] y_in,
	output logic [13:0]                 ang_out
);
	import fbik_pkg::*;

	logic [NORM_W-1:0]       nx_q [NORM_STAGES];
	logic [NORM_W-1:0]       ny_q [NORM_STAGES];
	logic                    nzx_q [NORM_STAGES];
	logic                    nzy_q [NORM_STAGES];
	logic signed [ROT_W-1:0] rx_q [CORDIC_STEPS];
	logic signed [ROT_W-1:0] ry_q [CORDIC_STEPS];
	logic signed [ACC_W-1:0] ra_q [CORDIC_STEPS];
	logic                    rzx_q [CORDIC_STEPS];
	logic                    rzy_q [CORDIC_STEPS];
	logic signed [ACC_W-1:0] rnd_c, rr_c;
	logic [13:0]             clamp_c, ang_q;

	genvar j, i;

	// normalise: shift left while both operands stay below 2^40
	for (j = 0; j < NORM_STAGES; j++) begin : g_norm
		localparam int SH = 32 >> j;
		logic [NORM_W-1:0] sx, sy, m;
		logic              szx, szy, do_sh;
		if (j == 0) begin : g_first
			assign sx  = x_in;
			assign sy  = y_in;
			assign szx = (x_in == '0);
			assign szy = (y_in == '0);
		end else begin : g_next
			assign sx  = nx_q[j-1];
			assign sy  = ny_q[j-1];
			assign szx = nzx_q[j-1];
			assign szy = nzy_q[j-1];
		end
		assign m     = sx | sy;
		assign do_sh = ((m >> (NORM_W - SH)) == '0);
		always_ff @(posedge clk) begin
			if (en) begin
				nx_q[j]  <= do_sh ? (sx << SH) : sx;
				ny_q[j]  <= do_sh ? (sy << SH) : sy;
				nzx_q[j] <= szx;
				nzy_q[j] <= szy;
			end
		end
	end

	for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [ROT_W-1:0] sx, sy, dx, dy;
		logic signed [ACC_W-1:0] sa, tab;
		logic                    szx, szy;
		if (i == 0) begin : g_first
			assign sx  = $signed(ROT_W'(nx_q[NORM_STAGES-1]));
			assign sy  = $signed(ROT_W'(ny_q[NORM_STAGES-1]));
			assign sa  = '0;
			assign szx = nzx_q[NORM_STAGES-1];
			assign szy = nzy_q[NORM_STAGES-1];
		end else begin : g_next
			assign sx  = rx_q[i-1];
			assign sy  = ry_q[i-1];
			assign sa  = ra_q[i-1];
			assign szx = rzx_q[i-1];
			assign szy = rzy_q[i-1];
		end
		assign dx  = sy >>> i;
		assign dy  = sx >>> i;
		assign tab = $signed(ACC_W'(atan_entry(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!sy[ROT_W-1]) begin
					rx_q[i] <= sx + dx;
					ry_q[i] <= sy - dy;
					ra_q[i] <= sa + tab;
				end else begin
					rx_q[i] <= sx - dx;
					ry_q[i] <= sy + dy;
					ra_q[i] <= sa - tab;
				end
				rzx_q[i] <= szx;
				rzy_q[i] <= szy;
			end
		end
	end

	// round to 1/64 degree, clamp to [0, 90]
	assign rnd_c = ra_q[CORDIC_STEPS-1] + ACC_W'(512);
	assign rr_c  = rnd_c >>> 10;

	always_comb begin
		if (rr_c[ACC_W-1]) begin
			clamp_c = '0;
		end else if (rr_c[ACC_W-2:0] > (ACC_W-1)'(ANG_90)) begin
			clamp_c = ANG_90;
		end else begin
			clamp_c = rr_c[13:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rzy_q[CORDIC_STEPS-1]) begin
				ang_q <= '0;
			end else if (rzx_q[CORDIC_STEPS-1]) begin
				ang_q <= ANG_90;
			end else begin
				ang_q <= clamp_c;
			end
		end
	end

	assign ang_out = ang_q;

endmodule

`default_nettype wire

>>> rtl/fbik_back.sv
// Arithmetic pipeline: cosine-law terms, bit-serial-per-stage square root,
// two CORDIC units and the final angle combine. Depends on fbik_pkg, fbik_cordic.
`default_nettype none

module fbik_back #(
	parameter int CORDIC_STEPS = fbik_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_WIDTH  = fbik_pkg::COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  fbik_pkg::fbik_item_t       in_item,
	input  logic [fbik_pkg::LEN_W-1:0] upper_len,
	input  logic [fbik_pkg::LEN_W-1:0] lower_len,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 leg_tag,
	output logic [fbik_pkg::ANGLE_W-1:0] front_angle,
	output logic [fbik_pkg::ANGLE_W-1:0] back_angle,
	output logic                       unreachable
);
	import fbik_pkg::*;

	localparam int CUT       = (COORD_WIDTH > 16) ? (COORD_WIDTH - 16) : 0;
	localparam int ISQ_STEPS = 32;
	localparam int CLAT      = NORM_STAGES + CORDIC_STEPS + 1;

	logic en;

	// stage 1: squares
	logic [15:0]      sx_c, sz_c;
	logic [LEN_W-1:0] up_c, dn_c;
	logic             v_s1;
	fbik_side_t       side_s1;
	logic [31:0]      sx2_s1, sz2_s1;
	logic [29:0]      up2_s1, dn2_s1;

	// stage 2: L^2 and N
	logic [31:0] l2_c;
	logic [33:0] n_c;
	logic        v_s2;
	fbik_side_t  side_s2;
	logic [31:0] l2_s2;
	logic [33:0] n_s2;
	logic [29:0] up2_s2;

	// stage 3: D^2 and N^2
	logic [61:0] dprod_c;
	logic [32:0] an_c;
	logic        v_s3;
	fbik_side_t  side_s3;
	logic [63:0] d2_s3, n2_s3;
	logic [32:0] an_s3;

	// stage 4: reach test
	logic        v_s4;
	fbik_side_t  side_s4;
	logic [63:0] rad_s4;
	logic [32:0] an_s4;

	// square root stages
	logic        isq_v_q    [ISQ_STEPS];
	fbik_side_t  isq_side_q [ISQ_STEPS];
	logic [32:0] isq_an_q   [ISQ_STEPS];
	logic [63:0] isq_rem_q  [ISQ_STEPS];
	logic [63:0] isq_root_q [ISQ_STEPS];

	// side line beside the CORDIC units
	logic       dly_v_q    [CLAT];
	fbik_side_t dly_side_q [CLAT];

	logic [13:0] phi, alpha, gamma_c, a_c;
	fbik_side_t  fin_side;

	logic                 out_valid_q, flag_q;
	logic [1:0]           tag_q;
	logic [ANGLE_W-1:0]   front_q, back_q, diff_c;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign sx_c = 16'(in_item.ax >> CUT);
	assign sz_c = 16'(in_item.az >> CUT);
	assign up_c = LEN_W'(upper_len >> CUT);
	assign dn_c = LEN_W'(lower_len >> CUT);

	assign l2_c    = sx2_s1 + sz2_s1;
	assign n_c     = 34'(l2_c) + 34'(up2_s1) - 34'(dn2_s1);
	assign dprod_c = 62'(up2_s2) * 62'(l2_s2);
	assign an_c    = n_s2[33] ? 33'(-n_s2) : n_s2[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.item  <= in_item;
			side_s1.flag  <= 1'b0;
			side_s1.n_neg <= 1'b0;
			sx2_s1 <= sx_c * sx_c;
			sz2_s1 <= sz_c * sz_c;
			up2_s1 <= up_c * up_c;
			dn2_s1 <= dn_c * dn_c;

			side_s2 <= side_s1;
			l2_s2   <= l2_c;
			n_s2    <= n_c;
			up2_s2  <= up2_s1;

			side_s3.item  <= side_s2.item;
			side_s3.flag  <= side_s2.flag;
			side_s3.n_neg <= n_s2[33];
			d2_s3 <= {dprod_c, 2'b00};
			n2_s3 <= 64'(an_c) * 64'(an_c);
			an_s3 <= an_c;

			side_s4.item  <= side_s3.item;
			side_s4.flag  <= (d2_s3 == '0) || (n2_s3 > d2_s3);
			side_s4.n_neg <= side_s3.n_neg;
			rad_s4 <= d2_s3 - n2_s3;
			an_s4  <= an_s3;
		end
	end

	// floor square root, one result bit per stage
	genvar k;
	for (k = 0; k < ISQ_STEPS; k++) begin : g_isq
		localparam logic [63:0] BITV = 64'(1) << (62 - 2*k);
		logic        sv;
		fbik_side_t  sside;
		logic [32:0] san;
		logic [63:0] srem, sroot;
		logic [64:0] trial;
		if (k == 0) begin : g_first
			assign sv    = v_s4;
			assign sside = side_s4;
			assign san   = an_s4;
			assign srem  = rad_s4;
			assign sroot = '0;
		end else begin : g_next
			assign sv    = isq_v_q[k-1];
			assign sside = isq_side_q[k-1];
			assign san   = isq_an_q[k-1];
			assign srem  = isq_rem_q[k-1];
			assign sroot = isq_root_q[k-1];
		end
		assign trial = {1'b0, sroot} + {1'b0, BITV};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				isq_v_q[k] <= 1'b0;
			end else if (en) begin
				isq_v_q[k] <= sv;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				isq_side_q[k] <= sside;
				isq_an_q[k]   <= san;
				if ({1'b0, srem} >= trial) begin
					isq_rem_q[k]  <= srem - trial[63:0];
					isq_root_q[k] <= (sroot >> 1) + BITV;
				end else begin
					isq_rem_q[k]  <= srem;
					isq_root_q[k] <= sroot >> 1;
				end
			end
		end
	end

	fbik_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_gamma (
		.clk     (clk),
		.en      (en),
		.x_in    (NORM_W'(isq_side_q[ISQ_STEPS-1].item.ax)),
		.y_in    (NORM_W'(isq_side_q[ISQ_STEPS-1].item.az)),
		.ang_out (phi)
	);

	fbik_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_alpha (
		.clk     (clk),
		.en      (en),
		.x_in    (NORM_W'(isq_an_q[ISQ_STEPS-1])),
		.y_in    (NORM_W'(isq_root_q[ISQ_STEPS-1][31:0])),
		.ang_out (alpha)
	);

	for (k = 0; k < CLAT; k++) begin : g_dly
		logic       sv;
		fbik_side_t sside;
		if (k == 0) begin : g_first
			assign sv    = isq_v_q[ISQ_STEPS-1];
			assign sside = isq_side_q[ISQ_STEPS-1];
		end else begin : g_next
			assign sv    = dly_v_q[k-1];
			assign sside = dly_side_q[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_v_q[k] <= 1'b0;
			end else if (en) begin
				dly_v_q[k] <= sv;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dly_side_q[k] <= sside;
			end
		end
	end

	assign fin_side = dly_side_q[CLAT-1];

	always_comb begin
		if (fin_side.item.x_zero) begin
			gamma_c = ANG_90;
		end else if (fin_side.item.same_sign) begin
			gamma_c = ANG_180 - phi;
		end else begin
			gamma_c = phi;
		end
		// saturated argument: +1 gives 0, -1 gives 180 degrees
		if (fin_side.flag) begin
			a_c = fin_side.n_neg ? ANG_180 : '0;
		end else if (fin_side.n_neg) begin
			a_c = ANG_180 - alpha;
		end else begin
			a_c = alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dly_v_q[CLAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q   <= fin_side.item.tag;
			front_q <= ANGLE_W'(gamma_c) - ANGLE_W'(a_c);
			back_q  <= ANGLE_W'(gamma_c) + ANGLE_W'(a_c);
			flag_q  <= fin_side.flag;
		end
	end

	assign out_valid   = out_valid_q;
	assign leg_tag     = tag_q;
	assign front_angle = front_q;
	assign back_angle  = back_q;
	assign unreachable = flag_q;
	assign diff_c      = back_q - front_q;

	a_sat_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && flag_q |-> (diff_c == '0 || diff_c == BACK_MAX))
		else $error("saturated result with cosine angle other than 0 or 180");

	a_back_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (back_q <= BACK_MAX))
		else $error("back angle out of range");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && dly_v_q[CLAT-1] |=> out_valid_q)
		else $error("item lost between last stage and output register");

endmodule

`default_nettype wire

>>> rtl/five_bar_leg_inverse_kinematics.sv
// Top level of the five-bar leg inverse kinematics block.
// Depends on fbik_pkg, fbik_front, fbik_queue, fbik_back.
//
// Use:
//   s_* stream: one foot target per item; tdata = leg_index, foot_x, foot_z.
//   m_* stream: one result per item, in order; tdata = leg_tag, front_angle,
//   back_angle; tuser = unreachable (target out of reach or at the origin,
//   angles then saturated to a cosine angle of 0 or 180 degrees).
//   cfg_we/cfg_index/cfg_data write the upper (index 0) and lower (index 1)
//   link lengths; write them only while no item is in flight.
// Throughput: one item per clock, sustained while the output is not stalled. Every stage is pipelined: four
// cosine-law stages with multipliers, a 32-stage square root (one root bit per
// stage) and two CORDIC units of 6 normalise stages, CORDIC_STEPS rotation
// stages and one rounding stage, running side by side.
// Path from input acceptance to the result: the front register, the queue, the
// cosine-law stages, the square root, the CORDIC units and the output register.
// Reset: pipeline and queue empty, link lengths 1600 and 3200 (1/16 mm).
// Output stall: the whole arithmetic pipeline holds; the front register and a
// four-entry queue keep taking items until they fill, then s_tready drops.
`default_nettype none

module five_bar_leg_inverse_kinematics #(
	parameter int CORDIC_STEPS = fbik_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_WIDTH  = fbik_pkg::COORD_WIDTH_DEF,
	localparam int IN_W = ((2 + 2*COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// leg_index [1:0], foot_x, foot_z (COORD_WIDTH each), zero pad
	input  logic [IN_W-1:0]            s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// leg_tag [1:0], front_angle [16:2], back_angle [31:17]
	output logic [31:0]                m_tdata,
	// unreachable [0]
	output logic                       m_tuser,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [fbik_pkg::LEN_W-1:0] cfg_data
);
	import fbik_pkg::*;

	logic [LEN_W-1:0]       upper_q, lower_q;
	logic [COORD_WIDTH-1:0] foot_x, foot_z;
	logic                   f_valid, f_ready, q_valid, q_ready;
	fbik_item_t             f_item, q_item;
	logic [1:0]             leg_tag;
	logic [ANGLE_W-1:0]     front_angle, back_angle;

	// link length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LEN_W'(1600);
			lower_q <= LEN_W'(3200);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPPER: upper_q <= cfg_data;
				REG_LOWER: lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign foot_x = s_tdata[2 +: COORD_WIDTH];
	assign foot_z = s_tdata[2 + COORD_WIDTH +: COORD_WIDTH];

	fbik_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.leg_index (s_tdata[1:0]),
		.foot_x    (foot_x),
		.foot_z    (foot_z),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	fbik_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	fbik_back #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_ready    (q_ready),
		.in_item     (q_item),
		.upper_len   (upper_q),
		.lower_len   (lower_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.leg_tag     (leg_tag),
		.front_angle (front_angle),
		.back_angle  (back_angle),
		.unreachable (m_tuser)
	);

	assign m_tdata = {back_angle, front_angle, leg_tag};

endmodule

`default_nettype wire

>>> dv/fbik_checker.sv
// Result checker for the five-bar leg IK block: watches both streams and the link-length writes.
// Depends on fbik_pkg; predicts each result and compares it with what the block returns.
`default_nettype none

module fbik_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fbik_pkg::*;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [1:0]  tag;
		logic [14:0] front;
		logic [14:0] back;
		logic        unreach;
	} leg_angles_t;

	leg_angles_t angle_q[$];
	longint upper_len, lower_len;

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -1 - ((-1 - v) >>> s);
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	// vectoring arctangent, result in 1/64 degree, clamped to [0, 90]
	function automatic longint vec_atan(longint x, longint y);
		longint ang, dx, dy, r;
		if (y == 0)
			return 0;
		if (x == 0)
			return 5760;
		ang = 0;
		while (x < (64'sd1 << 40) && y < (64'sd1 << 40)) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				ang = ang + longint'(atan_entry(i));
			end else begin
				x = x - dx;
				y = y + dy;
				ang = ang - longint'(atan_entry(i));
			end
		end
		r = floor_shr(ang + 512, 10);
		if (r < 0)
			r = 0;
		if (r > 5760)
			r = 5760;
		return r;
	endfunction

	function automatic leg_angles_t solve_leg(logic [1:0] tag, logic signed [15:0] fx,
			logic signed [15:0] fz);
		longint x, z, ax, az, l2, n, an, d2, gam, a, phi;
		u64_t d2u, n2u;
		leg_angles_t res;
		x = fx;
		z = fz;
		ax = x < 0 ? -x : x;
		az = z < 0 ? -z : z;
		l2 = ax * ax + az * az;
		n = l2 + upper_len * upper_len - lower_len * lower_len;
		d2 = 4 * upper_len * upper_len * l2;
		an = (n < 0 ? -n : n);
		// N^2 can pass 2^63, so the reach test is unsigned
		d2u = u64_t'(d2);
		n2u = u64_t'(an) * u64_t'(an);
		res.unreach = 1'b0;
		if (x == 0) begin
			gam = 5760;
		end else begin
			phi = vec_atan(ax, az);
			gam = ((x > 0 && z > 0) || (x < 0 && z < 0)) ? 11520 - phi : phi;
		end
		if (l2 == 0 || d2u == 0 || n2u > d2u) begin
			res.unreach = 1'b1;
			a = n < 0 ? 11520 : 0;
		end else if (n >= 0) begin
			a = vec_atan(n, int_sqrt(longint'(d2u - n2u)));
		end else begin
			a = 11520 - vec_atan(-n, int_sqrt(longint'(d2u - n2u)));
		end
		res.tag = tag;
		res.front = 15'(gam - a);
		res.back = 15'(gam + a);
		return res;
	endfunction

	assign pending = angle_q.size();

	always @(posedge clk or negedge arst_n) begin
		leg_angles_t want;
		leg_angles_t got;
		if (!arst_n) begin
			upper_len <= 1600;
			lower_len <= 3200;
			fail_count <= 0;
			angle_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_UPPER)
					upper_len <= cfg_data;
				else
					lower_len <= cfg_data;
			end
			if (s_tvalid && s_tready)
				angle_q.push_back(solve_leg(s_tdata[1:0], s_tdata[17:2], s_tdata[33:18]));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[16:2], m_tdata[31:17], m_tuser};
				if (angle_q.size() == 0) begin
					$display("%0t: result with none expected: %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = angle_q.pop_front();
					if (want !== got) begin
						$display({"%0t: mismatch expected tag %0d front %0d back %0d",
							" unr %0b, actual tag %0d front %0d back %0d unr %0b"},
							$time, want.tag, $signed(want.front), want.back, want.unreach,
							got.tag, $signed(got.front), got.back, got.unreach);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

>>> dv/five_bar_leg_inverse_kinematics_tb.sv
// Testbench top for the five-bar leg IK block: drives foot targets and link lengths.
// Depends on fbik_pkg, the block and fbik_checker, which does all result checking.
`default_nettype none

module five_bar_leg_inverse_kinematics_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fbik_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // leg_index [1:0], foot_x [17:2], foot_z [33:18], pad
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // leg_tag [1:0], front_angle [16:2], back_angle [31:17]
	logic        m_tuser;    // unreachable [0]
	logic        cfg_we;
	logic        cfg_index;
	logic [14:0] cfg_data;
	int          fail_count;
	int          pending;
	int          send_idle;  // percent of cycles the sender holds off
	int          sink_stall; // percent of cycles the receiver stalls
	longint      cycles = 0;

	five_bar_leg_inverse_kinematics DUT (.*);
	fbik_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// timeout: worst case is ~1720 items each spread over long stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_stall);
	end

	// offer one foot target, with random hold-off before it, and wait for acceptance
	task automatic send_target(logic [1:0] leg, logic [15:0] fx, logic [15:0] fz);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, fz, fx, leg};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// wait until the pipeline has drained, plus a margin for the block's latency
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// caller drops cfg_we after the last write
	task automatic write_link(reg_idx_t idx, logic [14:0] len);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= len;
		@(posedge clk);
	endtask

	// mostly targets near the reachable annulus, some near the origin, the rest anywhere
	task automatic random_target();
		int r;
		int sx;
		int sz;
		r = $urandom_range(99);
		if (r < 70) begin
			sx = $signed($urandom_range(8000)) - 4000;
			sz = $signed($urandom_range(8000)) - 6000;
		end else if (r < 80) begin
			sx = $urandom_range(7) == 0 ? 0 : $signed($urandom_range(64)) - 32;
			sz = $signed($urandom_range(64)) - 32;
		end else begin
			sx = $signed($urandom_range(65535)) - 32768;
			sz = $signed($urandom_range(65535)) - 32768;
		end
		send_target(2'($urandom_range(3)), 16'(sx), 16'(sz));
	endtask

	initial begin
		logic [14:0] up_set[5] = '{1600, 1, 32767, 3000, 500};
		logic [14:0] dn_set[5] = '{3200, 32767, 1, 3000, 2500};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_UPPER;
		cfg_data = '0;
		send_idle = 0;
		sink_stall = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, origin, axes, every quadrant, reach limits
		send_target(2'd0, 16'd0, 16'd0);
		send_target(2'd1, 16'h7fff, 16'h7fff);
		send_target(2'd2, 16'h8000, 16'h8000);
		send_target(2'd3, 16'h7fff, 16'h8000);
		send_target(2'd0, 16'h8000, 16'h7fff);
		send_target(2'd1, 16'd0, -16'sd3000);
		send_target(2'd2, 16'd0, 16'sd3000);
		send_target(2'd3, 16'sd3000, 16'd0);
		send_target(2'd0, -16'sd3000, 16'd0);
		send_target(2'd1, 16'sd1000, -16'sd2500);
		send_target(2'd2, -16'sd1000, -16'sd2500);
		send_target(2'd3, 16'sd1000, 16'sd2500);
		send_target(2'd0, -16'sd1000, 16'sd2500);
		send_target(2'd1, 16'd0, -16'sd4800);   // exactly at full reach
		send_target(2'd2, 16'd0, -16'sd1600);   // exactly at inner reach
		send_target(2'd3, 16'd0, -16'sd1599);   // just inside the dead zone
		send_target(2'd0, 16'd1, 16'd0);
		send_target(2'd1, 16'hffff, 16'hffff);
		drain();

		// five link settings, each run under four idling patterns
		for (int c = 0; c < 5; c++) begin
			write_link(REG_UPPER, up_set[c]);
			write_link(REG_LOWER, dn_set[c]);
			cfg_we <= 1'b0;
			for (int ph = 0; ph < 4; ph++) begin
				send_idle = (ph == 1) ? 48 : (ph == 3) ? 20 : 0;
				sink_stall = (ph == 2) ? 48 : (ph == 3) ? 20 : 0;
				for (int k = 0; k < 85; k++)
					random_target();
			end
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

`default_nettype wire

>>> sim.f
rtl/fbik_pkg.sv
rtl/fbik_front.sv
rtl/fbik_queue.sv
rtl/fbik_cordic.sv
rtl/fbik_back.sv
rtl/five_bar_leg_inverse_kinematics.sv
dv/fbik_checker.sv
dv/five_bar_leg_inverse_kinematics_tb.sv
